// ===== rtl/fwnta_pkg.sv =====
package fwnta_pkg;

  // request modes, coded as on the req_type field
  typedef enum logic [1:0] {
    REQ_UDEC = 2'd0,
    REQ_SDEC = 2'd1,
    REQ_HEX  = 2'd2,
    REQ_BIN  = 2'd3
  } req_type_t;

  localparam int NUM_W    = 32;
  localparam int CNT_W    = 6;
  localparam int LINE_W   = 3;
  localparam int COL_W    = 5;
  localparam int OCOL_W   = 6;
  localparam int CHAR_W   = 7;
  localparam int BCD_DIGS = 10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  // mode maxima before the MAX_DIGITS cap
  localparam int MODE_MAX_DEC = 10;
  localparam int MODE_MAX_HEX = 8;
  localparam int MODE_MAX_BIN = 32;

  // one classified request waiting for the back end
  typedef struct packed {
    req_type_t          mode;
    logic [NUM_W-1:0]   value;   // magnitude in signed mode
    logic               neg;
    logic [CNT_W-1:0]   total;   // characters to emit, sign included
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
  } job_t;

  // queue status seen by the front and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_CONVERT = 2'd1,
    BK_EMIT    = 2'd2
  } back_state_t;

endpackage

// ===== rtl/fwnta_if.sv =====
interface fwnta_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [31:0]               number;
  logic [5:0]                digit_count;
  logic [2:0]                line;
  logic [4:0]                start_column;

  modport source (output valid, req_type, number, digit_count, line, start_column,
                  input ready);
  modport sink   (input valid, req_type, number, digit_count, line, start_column,
                  output ready);
endinterface

interface fwnta_char_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_line;
  logic [5:0] out_column;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, out_line, out_column, char_code, last, input ready);
  modport sink   (input valid, out_line, out_column, char_code, last, output ready);
endinterface

// ===== rtl/fixed_width_number_to_ascii_unit.sv =====
// channel | dir | payload                                         | handshake
// req     | in  | req_type, number, digit_count, line, start_column | valid/ready
// chars   | out | out_line, out_column, char_code, last             | valid/ready
//
// a request enters a two-entry queue in the cycle it is accepted
// decimal modes then pass through the shift-and-add-3 converter,
// hex and binary skip it; characters then go out one at a time, held by a stall on chars
// reset clears the queue pointers, the back-end state and the output valid flag only
// a stall on chars holds the character register; req keeps flowing until the queue fills
module fixed_width_number_to_ascii_unit #(
  parameter int MAX_DIGITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  fwnta_req_if.sink    req,
  fwnta_char_if.source chars
);
  import fwnta_pkg::*;

  // front to queue
  logic        push;
  job_t        wr_job;
  // queue to back end
  job_t        rd_job;
  logic        pop;
  queue_stat_t stat;

  // classify: saturate the count, take the magnitude, add the sign slot
  fwnta_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .req  (req),
    .stat (stat),
    .push (push),
    .job  (wr_job)
  );

  // decouples accepting from emitting
  fwnta_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (stat)
  );

  // bcd conversion and one character per cycle while chars is ready
  fwnta_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd_job (rd_job),
    .stat   (stat),
    .pop    (pop),
    .chars  (chars)
  );

endmodule

// ===== rtl/fwnta_front.sv =====
module fwnta_front #(
  parameter int MAX_DIGITS = 32
) (
  fwnta_req_if.sink             req,
  input  fwnta_pkg::queue_stat_t stat,
  output logic                  push,
  output fwnta_pkg::job_t       job
);
  import fwnta_pkg::*;

  localparam int CAP_UDEC = (MODE_MAX_DEC < MAX_DIGITS) ? MODE_MAX_DEC : MAX_DIGITS;
  localparam int CAP_SDEC = (MODE_MAX_DEC < MAX_DIGITS - 1) ? MODE_MAX_DEC : MAX_DIGITS - 1;
  localparam int CAP_HEX  = (MODE_MAX_HEX < MAX_DIGITS) ? MODE_MAX_HEX : MAX_DIGITS;
  localparam int CAP_BIN  = (MODE_MAX_BIN < MAX_DIGITS) ? MODE_MAX_BIN : MAX_DIGITS;

  req_type_t        mode;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] count;
  logic             neg;

  assign mode = req_type_t'(req.req_type);

  always_comb begin
    unique case (mode)
      REQ_UDEC: cap = CNT_W'(CAP_UDEC);
      REQ_SDEC: cap = CNT_W'(CAP_SDEC);
      REQ_HEX:  cap = CNT_W'(CAP_HEX);
      default:  cap = CNT_W'(CAP_BIN);
    endcase
  end

  assign count = (req.digit_count > cap) ? cap : req.digit_count;
  assign neg   = (mode == REQ_SDEC) && req.number[NUM_W-1];

  always_comb begin
    job.mode  = mode;
    job.value = neg ? (NUM_W'(0) - req.number) : req.number;
    job.neg   = neg;
    job.total = (mode == REQ_SDEC) ? count + CNT_W'(1) : count;
    job.line  = req.line;
    job.col   = req.start_column;
  end

  assign req.ready = !stat.full;
  assign push      = req.valid && !stat.full;

endmodule

// ===== rtl/fwnta_queue.sv =====
module fwnta_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fwnta_pkg::job_t        wr_job,
  input  logic                   pop,
  output fwnta_pkg::job_t        rd_job,
  output fwnta_pkg::queue_stat_t stat
);
  import fwnta_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign stat.full  = (fill == (PTR_W+1)'(DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== rtl/fwnta_back.sv =====
module fwnta_back (
  input  logic                   clk,
  input  logic                   rst,
  input  fwnta_pkg::job_t        rd_job,
  input  fwnta_pkg::queue_stat_t stat,
  output logic                   pop,
  fwnta_char_if.source           chars
);
  import fwnta_pkg::*;

  localparam int ITER_W = $clog2(NUM_W);

  back_state_t      state;
  back_state_t      state_next;
  job_t             cur;
  logic [3:0]       bcd [BCD_DIGS];
  logic [NUM_W-1:0] shreg;
  logic [ITER_W-1:0] iter;
  logic [CNT_W-1:0] pos;

  logic             conv_step;
  logic             out_load;
  logic             is_dec;
  logic             last_char;
  logic [CNT_W-1:0] k;
  logic [3:0]       digit;
  logic [CHAR_W-1:0] code;
  logic [3:0]       bcd_adj [BCD_DIGS];

  logic              out_valid;
  logic [LINE_W-1:0] out_line;
  logic [OCOL_W-1:0] out_column;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  assign is_dec    = (rd_job.mode == REQ_UDEC) || (rd_job.mode == REQ_SDEC);
  assign last_char = (pos == cur.total - CNT_W'(1));

  // fsm outputs
  always_comb begin
    pop       = 1'b0;
    conv_step = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      BK_IDLE:    pop       = !stat.empty;
      BK_CONVERT: conv_step = 1'b1;
      BK_EMIT:    out_load  = !out_valid || chars.ready;
      default: ;
    endcase
  end

  // fsm next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!stat.empty && rd_job.total != '0) begin
          state_next = is_dec ? BK_CONVERT : BK_EMIT;
        end
      end
      BK_CONVERT: begin
        if (iter == ITER_W'(NUM_W - 1)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_load && last_char) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // add-3 adjust ahead of each shift
  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // character at the current position
  assign k = cur.total - CNT_W'(1) - pos;

  always_comb begin
    unique case (cur.mode)
      REQ_HEX: digit = cur.value[k[2:0]*4 +: 4];
      REQ_BIN: digit = {3'b000, cur.value[k[4:0]]};
      default: digit = (k[3:0] < 4'(BCD_DIGS)) ? bcd[k[3:0]] : 4'd0;
    endcase
    if (cur.mode == REQ_SDEC && pos == '0) begin
      code = cur.neg ? ASCII_MINUS : ASCII_PLUS;
    end else if (digit < 4'd10) begin
      code = ASCII_ZERO + CHAR_W'(digit);
    end else begin
      code = ASCII_A + CHAR_W'(digit - 4'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= rd_job;
      shreg <= rd_job.value;
      iter  <= '0;
      pos   <= '0;
      for (int i = 0; i < BCD_DIGS; i++) begin
        bcd[i] <= 4'd0;
      end
    end
    if (conv_step) begin
      shreg <= {shreg[NUM_W-2:0], 1'b0};
      iter  <= iter + ITER_W'(1);
      bcd[0] <= {bcd_adj[0][2:0], shreg[NUM_W-1]};
      for (int i = 1; i < BCD_DIGS; i++) begin
        bcd[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
      end
    end
    if (out_load) begin
      pos        <= pos + CNT_W'(1);
      out_line   <= cur.line;
      out_column <= OCOL_W'(cur.col) + pos;
      char_code  <= code;
      last       <= last_char;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.out_line   = out_line;
  assign chars.out_column = out_column;
  assign chars.char_code  = char_code;
  assign chars.last       = last;

endmodule

// ===== sim/fixed_width_number_to_ascii_unit_test.sv =====
module fixed_width_number_to_ascii_unit_test;
  import fwnta_pkg::*;

  localparam int MAX_DIGITS = 32;
  // percent of cycles in which each side holds back
  localparam int IDLE_PCT = 21;
  // random items after the directed ones
  localparam int RANDOM_ITEMS = 361;
  // items accepted in this window see no idling on either side
  localparam int STEADY_FROM = 150;
  localparam int STEADY_TO = 250;
  // quiet tail after the last owed character, so that any extra character is caught
  localparam int DRAIN_CYCLES = 100;
  localparam int TIMEOUT = 1200000;

  // one number to print, as it goes over the req channel
  typedef struct packed {
    req_type_t          mode;
    logic [NUM_W-1:0]   number;
    logic [CNT_W-1:0]   count;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
  } num_req_t;

  // one character, as it comes back on the chars channel
  typedef struct packed {
    logic [LINE_W-1:0]  line;
    logic [OCOL_W-1:0]  column;
    logic [CHAR_W-1:0]  code;
    logic               last;
  } char_item_t;

  logic clk;
  logic rst;

  fwnta_req_if  req_bus ();
  fwnta_char_if char_bus ();

  fixed_width_number_to_ascii_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_bus),
    .chars(char_bus)
  );

  num_req_t   req_queue[$];       // numbers still to be sent
  num_req_t   req_in_flight;      // number currently on the req channel
  logic       req_busy;           // req_in_flight waits for acceptance
  char_item_t expected_chars[$];  // characters the block still owes

  int unsigned reqs_accepted;
  int unsigned chars_checked;
  int unsigned errors;
  int unsigned mode_seen[4];

  // no idling while the accepted count sits in the steady window
  wire steady = (reqs_accepted >= STEADY_FROM) && (reqs_accepted < STEADY_TO);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected text for one number: optional sign, then the low digits, msd first
  function automatic void predict_chars(input num_req_t r);
    int unsigned mode_cap;
    int unsigned shown;
    int unsigned pos;
    int unsigned k;
    int unsigned d;
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] scaled;
    logic neg;
    char_item_t c;
    case (r.mode)
      REQ_UDEC: mode_cap = (MODE_MAX_DEC < MAX_DIGITS) ? MODE_MAX_DEC : MAX_DIGITS;
      // the sign takes one of the MAX_DIGITS slots
      REQ_SDEC: mode_cap = (MODE_MAX_DEC < MAX_DIGITS - 1) ? MODE_MAX_DEC : MAX_DIGITS - 1;
      REQ_HEX:  mode_cap = (MODE_MAX_HEX < MAX_DIGITS) ? MODE_MAX_HEX : MAX_DIGITS;
      default:  mode_cap = (MODE_MAX_BIN < MAX_DIGITS) ? MODE_MAX_BIN : MAX_DIGITS;
    endcase
    shown = (r.count > mode_cap) ? mode_cap : r.count;
    neg = (r.mode == REQ_SDEC) && r.number[NUM_W-1];
    // most negative value wraps to its own magnitude, read as unsigned
    mag = neg ? -r.number : r.number;
    pos = 0;
    c.line = r.line;
    if (r.mode == REQ_SDEC) begin
      c.column = OCOL_W'(r.col + pos);
      c.code = neg ? ASCII_MINUS : ASCII_PLUS;
      // with no digits the sign closes the number
      c.last = (shown == 0);
      expected_chars.push_back(c);
      pos++;
    end
    for (int i = 0; i < shown; i++) begin
      k = shown - 1 - i;
      case (r.mode)
        REQ_HEX: d = (mag >> (4 * k)) & 32'hF;
        REQ_BIN: d = mag[k];
        default: begin
          scaled = mag;
          repeat (k) scaled = scaled / 10;
          d = scaled % 10;
        end
      endcase
      c.column = OCOL_W'(r.col + pos);
      c.code = (d < 10) ? CHAR_W'(ASCII_ZERO + d) : CHAR_W'(ASCII_A + d - 10);
      c.last = (i + 1 == shown);
      expected_chars.push_back(c);
      pos++;
    end
  endfunction

  function automatic num_req_t make_req(input req_type_t mode, input logic [NUM_W-1:0] number,
                                        input int unsigned count, input int unsigned line,
                                        input int unsigned col);
    num_req_t r;
    r.mode = mode;
    r.number = number;
    r.count = CNT_W'(count);
    r.line = LINE_W'(line);
    r.col = COL_W'(col);
    return r;
  endfunction

  function automatic num_req_t random_request();
    num_req_t r;
    int unsigned cap;
    r.mode = req_type_t'($urandom_range(0, 3));
    // values near digit and sign boundaries are where converters break
    case ($urandom_range(0, 5))
      0: r.number = $urandom;
      1: r.number = $urandom_range(0, 999);
      2: r.number = -$urandom_range(1, 1000);
      3: r.number = $urandom >> $urandom_range(0, 31);
      4: begin
        case ($urandom_range(0, 9))
          0: r.number = 32'h0000_0000;
          1: r.number = 32'hFFFF_FFFF;
          2: r.number = 32'h8000_0000;
          3: r.number = 32'h7FFF_FFFF;
          4: r.number = 32'h8000_0001;
          5: r.number = 32'd999_999_999;
          6: r.number = 32'd1_000_000_000;
          7: r.number = 32'd4_000_000_000;
          8: r.number = 32'd9;
          default: r.number = 32'd10;
        endcase
      end
      default: r.number = $urandom + $urandom_range(0, 1) - $urandom_range(0, 1);
    endcase
    case (r.mode)
      REQ_HEX: cap = MODE_MAX_HEX;
      REQ_BIN: cap = MODE_MAX_BIN;
      default: cap = MODE_MAX_DEC;
    endcase
    // mostly in range, now and then empty or at or past the mode maximum
    case ($urandom_range(0, 19))
      0:       r.count = '0;
      1, 2:    r.count = CNT_W'($urandom_range(cap, 63));
      default: r.count = CNT_W'($urandom_range(1, cap));
    endcase
    r.line = LINE_W'($urandom);
    r.col = COL_W'($urandom);
    return r;
  endfunction

  // req driver: a new number may follow the accepted one with no gap
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_busy) begin
      if (req_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req_in_flight = req_queue.pop_front();
        req_bus.req_type <= req_in_flight.mode;
        req_bus.number <= req_in_flight.number;
        req_bus.digit_count <= req_in_flight.count;
        req_bus.line <= req_in_flight.line;
        req_bus.start_column <= req_in_flight.col;
        req_bus.valid <= 1'b1;
        req_busy = 1'b1;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // chars back pressure
  always @(negedge clk) begin
    if (rst) begin
      char_bus.ready <= 1'b0;
    end else begin
      char_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // req acceptance turns into expected characters
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      predict_chars(req_in_flight);
      mode_seen[req_in_flight.mode]++;
      reqs_accepted++;
      req_busy = 1'b0;
    end
  end

  // chars monitor: every accepted character against the oldest expectation
  always @(posedge clk) begin
    char_item_t want;
    char_item_t got;
    if (!rst && char_bus.valid && char_bus.ready) begin
      got.line = char_bus.out_line;
      got.column = char_bus.out_column;
      got.code = char_bus.char_code;
      got.last = char_bus.last;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected char: line %0d col %0d code %h last %b",
                   got.line, got.column, got.code, got.last);
        end
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (got.line !== want.line || got.column !== want.column ||
            got.code !== want.code || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("char mismatch: expected line %0d col %0d code %h last %b,",
                     want.line, want.column, want.code, want.last,
                     " got line %0d col %0d code %h last %b",
                     got.line, got.column, got.code, got.last);
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_busy = 1'b0;
    req_in_flight = '0;
    reqs_accepted = 0;
    chars_checked = 0;
    errors = 0;
    foreach (mode_seen[m]) mode_seen[m] = 0;
    req_bus.valid = 1'b0;
    req_bus.req_type = '0;
    req_bus.number = '0;
    req_bus.digit_count = '0;
    req_bus.line = '0;
    req_bus.start_column = '0;
    char_bus.ready = 1'b0;

    // directed: full-width values, sign extremes, saturation, empty counts, edge columns
    req_queue.push_back(make_req(REQ_UDEC, 32'hFFFF_FFFF, 10, 1, 1));
    req_queue.push_back(make_req(REQ_UDEC, 32'h0000_0000, 10, 0, 0));
    req_queue.push_back(make_req(REQ_UDEC, 32'd1234567890, 4, 7, 31));
    req_queue.push_back(make_req(REQ_UDEC, 32'd4000000001, 63, 2, 5));
    req_queue.push_back(make_req(REQ_UDEC, 32'd77, 0, 3, 3));
    req_queue.push_back(make_req(REQ_SDEC, 32'h8000_0000, 10, 4, 16));
    req_queue.push_back(make_req(REQ_SDEC, 32'h7FFF_FFFF, 10, 5, 31));
    req_queue.push_back(make_req(REQ_SDEC, 32'hFFFF_FFFF, 3, 6, 2));
    req_queue.push_back(make_req(REQ_SDEC, 32'h0000_0000, 0, 1, 1));
    req_queue.push_back(make_req(REQ_SDEC, 32'h8000_0001, 0, 2, 9));
    req_queue.push_back(make_req(REQ_SDEC, 32'hFFFF_FF85, 40, 3, 0));
    req_queue.push_back(make_req(REQ_HEX, 32'hDEAD_BEEF, 8, 4, 1));
    req_queue.push_back(make_req(REQ_HEX, 32'h0123_ABCD, 32, 0, 31));
    req_queue.push_back(make_req(REQ_HEX, 32'hFEDC_BA98, 3, 7, 12));
    req_queue.push_back(make_req(REQ_HEX, 32'h1234_5678, 0, 1, 4));
    req_queue.push_back(make_req(REQ_BIN, 32'hAAAA_AAAA, 32, 2, 31));
    req_queue.push_back(make_req(REQ_BIN, 32'h5555_5555, 63, 5, 0));
    req_queue.push_back(make_req(REQ_BIN, 32'h8000_0001, 1, 6, 7));
    req_queue.push_back(make_req(REQ_BIN, 32'hFFFF_FFFF, 0, 3, 8));
    repeat (RANDOM_ITEMS) req_queue.push_back(random_request());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // everything sent, then every owed character seen, then a quiet tail
    while (req_queue.size() != 0 || req_busy) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d numbers: %0d unsigned, %0d signed, %0d hex, %0d binary",
             reqs_accepted, mode_seen[REQ_UDEC], mode_seen[REQ_SDEC],
             mode_seen[REQ_HEX], mode_seen[REQ_BIN]);
    $display("checked %0d characters, %0d mismatches", chars_checked, errors);
    if (errors == 0) begin
      $display("PASS fixed_width_number_to_ascii_unit");
    end else begin
      $display("FAIL fixed_width_number_to_ascii_unit");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT);
    $display("timeout with %0d characters still owed", expected_chars.size());
    $display("FAIL fixed_width_number_to_ascii_unit");
    $finish;
  end

endmodule
